[rtl/rc4_pkg.sv]
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Widths, codes, state encoding and the structs shared by the cipher modules.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int KEY_DEPTH  = 256;
  localparam int KEY_AW     = 8;
  localparam int KLEN_W     = 9;
  localparam int DROP_W     = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [KLEN_W-1:0] KEY_LENGTH_RST = 9'd16;
  localparam logic [DROP_W-1:0] DROP_COUNT_RST = 12'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH = 1'b0,
    CFG_DROP_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_DATA = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KSA_RD,
    ST_KSA_T,
    ST_KSA_U,
    ST_KSA_W,
    ST_PRGA_RD,
    ST_PRGA_A,
    ST_PRGA_B,
    ST_PRGA_OUT
  } state_e;

  typedef struct packed {
    logic [KLEN_W-1:0] key_length;
    logic [DROP_W-1:0] drop_count;
  } cfg_t;

  typedef struct packed {
    opcode_e           opcode;
    logic [BYTE_W-1:0] byte_in;
    logic              last_in;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              last_out;
    logic              not_keyed;
  } res_t;

  typedef struct packed {
    logic keyed;
    logic idle;
  } stat_t;

endpackage

[rtl/rc4_if.sv]
// ----------------------------------------------------------------------------
// RC4 stream channels
// Valid/ready channels for input requests and cipher results.
// ----------------------------------------------------------------------------
interface rc4_req_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] byte_in;
  logic              last_in;

  modport source (output valid, output opcode, output byte_in, output last_in,
                  input ready);
  modport sink   (input valid, input opcode, input byte_in, input last_in,
                  output ready);
endinterface

interface rc4_res_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic              last_out;
  logic              not_keyed;

  modport source (output valid, output byte_out, output last_out, output not_keyed,
                  input ready);
  modport sink   (input valid, input byte_out, input last_out, input not_keyed,
                  output ready);
endinterface

[rtl/rc4_core.sv]
// ----------------------------------------------------------------------------
// RC4 core
// Key store, permutation memory and the sequencer for key schedule,
// keystream drop and data encryption.
// ----------------------------------------------------------------------------
module rc4_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rc4_pkg::cfg_t  cfg_i,
  input  logic           req_valid_i,
  input  rc4_pkg::req_t  req_i,
  output logic           req_ready_o,
  input  logic           res_free_i,
  output logic           res_valid_o,
  output rc4_pkg::res_t  res_o,
  output rc4_pkg::stat_t stat_o
);
  import rc4_pkg::*;

  logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
  logic [BYTE_W-1:0] key_mem  [KEY_DEPTH];

  state_e state_q, state_d;

  logic              keyed_q, keyed_d;
  logic [KLEN_W-1:0] seen_q, seen_d;
  logic [KLEN_W-1:0] len_q, len_d;
  logic [DROP_W-1:0] drop_q, drop_d;
  logic [BYTE_W-1:0] i_q, i_d;
  logic [BYTE_W-1:0] j_q, j_d;
  logic [BYTE_W-1:0] n_q, n_d;
  logic [KEY_AW-1:0] kp_q, kp_d;
  logic [BYTE_W-1:0] a_q, a_d;
  logic [BYTE_W-1:0] b_q, b_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              last_q, last_d;

  logic              perm_we;
  logic [BYTE_W-1:0] perm_waddr, perm_wdata, perm_raddr, perm_rdata;
  logic              key_we;
  logic [KEY_AW-1:0] key_waddr, key_raddr;
  logic [BYTE_W-1:0] key_wdata, key_rdata;

  logic              accept;
  logic [KLEN_W-1:0] seen_base, seen_next, eff_len;
  logic              seen_room, sched_go, kp_last;
  logic [BYTE_W-1:0] i_inc, sum_ab, ks_byte, j_ksa, j_prga;

  assign req_ready_o = (state_q == ST_IDLE) &&
                       ((req_i.opcode == OP_KEY) || keyed_q || res_free_i);
  assign accept      = req_valid_i && req_ready_o;

  assign seen_base = keyed_q ? '0 : seen_q;
  assign seen_room = seen_base < KLEN_W'(KEY_DEPTH);
  assign seen_next = seen_room ? KLEN_W'(seen_base + KLEN_W'(1)) : seen_base;

  always_comb begin
    if (cfg_i.key_length == '0) begin
      eff_len = KLEN_W'(1);
    end else if (cfg_i.key_length > KLEN_W'(KEY_DEPTH)) begin
      eff_len = KLEN_W'(KEY_DEPTH);
    end else begin
      eff_len = cfg_i.key_length;
    end
  end

  assign sched_go = seen_next >= eff_len;
  assign kp_last  = (KLEN_W'({1'b0, kp_q}) + KLEN_W'(1)) == len_q;
  assign i_inc    = BYTE_W'(i_q + BYTE_W'(1));
  assign j_ksa    = BYTE_W'(j_q + perm_rdata + key_rdata);
  assign j_prga   = BYTE_W'(j_q + perm_rdata);
  assign sum_ab   = BYTE_W'(a_q + b_q);

  // forward the swapped pair; S[j] wins when i equals j
  always_comb begin
    if (sum_ab == j_q) begin
      ks_byte = a_q;
    end else if (sum_ab == i_q) begin
      ks_byte = b_q;
    end else begin
      ks_byte = perm_rdata;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.opcode == OP_KEY) begin
            state_d = sched_go ? ST_FILL : ST_IDLE;
          end else begin
            state_d = keyed_q ? ST_PRGA_A : ST_IDLE;
          end
        end
      end
      ST_FILL:    state_d = (n_q == '1) ? ST_KSA_RD : ST_FILL;
      ST_KSA_RD:  state_d = ST_KSA_T;
      ST_KSA_T:   state_d = ST_KSA_U;
      ST_KSA_U:   state_d = ST_KSA_W;
      ST_KSA_W: begin
        if (n_q == '1) begin
          state_d = (cfg_i.drop_count == '0) ? ST_IDLE : ST_PRGA_RD;
        end else begin
          state_d = ST_KSA_RD;
        end
      end
      ST_PRGA_RD: state_d = ST_PRGA_A;
      ST_PRGA_A:  state_d = ST_PRGA_B;
      ST_PRGA_B:  state_d = ST_PRGA_OUT;
      ST_PRGA_OUT: begin
        if (keyed_q) begin
          state_d = res_free_i ? ST_IDLE : ST_PRGA_OUT;
        end else begin
          state_d = (drop_q == DROP_W'(1)) ? ST_IDLE : ST_PRGA_RD;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    keyed_d     = keyed_q;
    seen_d      = seen_q;
    len_d       = len_q;
    drop_d      = drop_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    kp_d        = kp_q;
    a_d         = a_q;
    b_d         = b_q;
    data_d      = data_q;
    last_d      = last_q;
    perm_we     = 1'b0;
    perm_waddr  = n_q;
    perm_wdata  = n_q;
    perm_raddr  = i_inc;
    key_we      = 1'b0;
    key_waddr   = seen_base[KEY_AW-1:0];
    key_wdata   = req_i.byte_in;
    key_raddr   = kp_q;
    res_valid_o = 1'b0;
    res_o       = '{byte_out: data_q ^ ks_byte, last_out: last_q, not_keyed: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.opcode == OP_KEY)) begin
          keyed_d = 1'b0;
          key_we  = seen_room;
          seen_d  = seen_next;
          if (sched_go) begin
            len_d = eff_len;
            n_d   = '0;
          end
        end else if (accept) begin
          data_d = req_i.byte_in;
          last_d = req_i.last_in;
          if (!keyed_q) begin
            res_valid_o = 1'b1;
            res_o       = '{byte_out: '0, last_out: req_i.last_in, not_keyed: 1'b1};
          end
        end
      end
      ST_FILL: begin
        perm_we = 1'b1;
        n_d     = BYTE_W'(n_q + BYTE_W'(1));
        j_d     = '0;
        kp_d    = '0;
      end
      ST_KSA_RD: begin
        perm_raddr = n_q;
      end
      ST_KSA_T: begin
        a_d        = perm_rdata;
        j_d        = j_ksa;
        perm_raddr = j_ksa;
      end
      ST_KSA_U: begin
        perm_we    = 1'b1;
        perm_waddr = n_q;
        perm_wdata = perm_rdata;
      end
      ST_KSA_W: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = a_q;
        n_d        = BYTE_W'(n_q + BYTE_W'(1));
        kp_d       = kp_last ? '0 : KEY_AW'(kp_q + KEY_AW'(1));
        if (n_q == '1) begin
          i_d    = '0;
          j_d    = '0;
          drop_d = cfg_i.drop_count;
          if (cfg_i.drop_count == '0) begin
            keyed_d = 1'b1;
          end
        end
      end
      ST_PRGA_RD: begin
        perm_raddr = i_inc;
      end
      ST_PRGA_A: begin
        i_d        = i_inc;
        a_d        = perm_rdata;
        j_d        = j_prga;
        perm_raddr = j_prga;
      end
      ST_PRGA_B: begin
        b_d        = perm_rdata;
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = perm_rdata;
        perm_raddr = BYTE_W'(a_q + perm_rdata);
      end
      ST_PRGA_OUT: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = a_q;
        perm_raddr = sum_ab;
        if (keyed_q) begin
          res_valid_o = res_free_i;
        end else begin
          drop_d = DROP_W'(drop_q - DROP_W'(1));
          if (drop_q == DROP_W'(1)) begin
            keyed_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      keyed_q <= 1'b0;
      seen_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      keyed_q <= keyed_d;
      seen_q  <= seen_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    drop_q <= drop_d;
    n_q    <= n_d;
    kp_q   <= kp_d;
    a_q    <= a_d;
    b_q    <= b_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rdata <= perm_mem[perm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata <= key_mem[key_raddr];
  end

  assign stat_o = '{keyed: keyed_q, idle: state_q == ST_IDLE};

endmodule

[rtl/rc4_stream_cipher_unit.sv]
// ----------------------------------------------------------------------------
// RC4 stream cipher unit
// Collects key bytes, runs the key schedule and encrypts data bytes.
// Data byte: result computed in ST_PRGA_OUT, then registered at the output. No new
//   byte is taken until then: the single read port reads S[i], S[j], S[t] in turn.
// Early data byte: error result registered in the cycle after the request.
// Last key byte: fill, key schedule over all 256 entries and drop_count drops before ready.
// Reset clears control state only; the permutation is refilled at each key.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rc4_req_if.sink                        in_ch,
  rc4_res_if.source                      out_ch
);
  import rc4_pkg::*;

  cfg_t  cfg_q, cfg_d;
  res_t  out_q;
  logic  out_valid_q, out_valid_d;
  logic  out_free;
  req_t  req;
  res_t  res;
  logic  res_valid;
  stat_t stat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_LENGTH: cfg_d.key_length = cfg_data_i[KLEN_W-1:0];
        CFG_DROP_COUNT: cfg_d.drop_count = cfg_data_i[DROP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign req      = '{opcode: opcode_e'(in_ch.opcode), byte_in: in_ch.byte_in,
                      last_in: in_ch.last_in};
  assign out_free = !out_valid_q || out_ch.ready;

  rc4_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (in_ch.valid),
    .req_i       (req),
    .req_ready_o (in_ch.ready),
    .res_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .stat_o      (stat)
  );

  assign out_valid_d = res_valid || (out_valid_q && !out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{key_length: KEY_LENGTH_RST, drop_count: DROP_COUNT_RST};
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.byte_out  = out_q.byte_out;
  assign out_ch.last_out  = out_q.last_out;
  assign out_ch.not_keyed = out_q.not_keyed;

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result loaded while output register is occupied");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.not_keyed |-> out_ch.byte_out == '0)
    else $error("error result carries nonzero data");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready && (in_ch.opcode == OP_DATA) && stat.keyed
    |=> !in_ch.ready && !stat.idle)
    else $error("engine idle right after a keyed data request");

  a_key_unkeys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready && (in_ch.opcode == OP_KEY) |=> !stat.keyed)
    else $error("key request left the engine keyed");

endmodule
